// File: rtl/lcdnws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_pkg
// shared types and constants of the character lcd nibble write sequencer
// ----------------------------------------------------------------------------
package lcdnws_pkg;

  localparam int unsigned STEP_W = 5;
  localparam int unsigned HOLD_W = 14;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // request kinds
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_INSTR = 2'd1;
  localparam logic [1:0] CMD_CHAR = 2'd2;
  localparam logic [1:0] CMD_CURSOR = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_ON = 3'd6;

  // instruction codes
  localparam logic [7:0] CODE_CLEAR = 8'h01;
  localparam logic [7:0] CODE_DISPLAY_OFF = 8'h08;
  localparam logic [7:0] CODE_DDRAM = 8'h80;

  // hold times in microseconds
  localparam logic [HOLD_W-1:0] HOLD_STROBE = 14'd5;
  localparam logic [HOLD_W-1:0] HOLD_POWER_UP = 14'd16000;
  localparam logic [HOLD_W-1:0] HOLD_WAKE1 = 14'd5005;
  localparam logic [HOLD_W-1:0] HOLD_WAKE2 = 14'd205;
  localparam logic [HOLD_W-1:0] HOLD_WAKE4 = 14'd1005;
  localparam logic [HOLD_W-1:0] HOLD_CLEAR = 14'd2005;
  localparam logic [HOLD_W-1:0] HOLD_INSTR = 14'd55;

  // last step index of each run
  localparam logic [STEP_W-1:0] LAST_INIT = 5'd28;
  localparam logic [STEP_W-1:0] LAST_BYTE = 5'd3;
  // first step of the init instruction block
  localparam logic [STEP_W-1:0] INIT_INSTR_BASE = 5'd9;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic emit;
    logic last;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// File: rtl/lcdnws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_ctrl
// request acceptance and step counter of the lcd write sequencer
// ----------------------------------------------------------------------------
module lcdnws_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [1:0]               cmd,
  input  wire logic [2:0]               row,
  output logic                          busy,
  output lcdnws_pkg::ctrl_cmd_t         ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic [lcdnws_pkg::STEP_W-1:0] step, step_next;
  logic [lcdnws_pkg::STEP_W-1:0] last_idx, last_idx_next;
  logic accept;
  logic gives_steps;

  // cursor moves to rows four to seven are taken but emit nothing
  assign gives_steps = !((cmd == lcdnws_pkg::CMD_CURSOR) && row[2]);
  assign accept = start && (state == ST_IDLE);
  assign busy = (state == ST_RUN);

  always_comb begin
    state_next = state;
    step_next = step;
    last_idx_next = last_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept && gives_steps) begin
          state_next = ST_RUN;
          step_next = '0;
          last_idx_next = (cmd == lcdnws_pkg::CMD_INIT) ? lcdnws_pkg::LAST_INIT
                                                        : lcdnws_pkg::LAST_BYTE;
        end
      end
      ST_RUN: begin
        if (step == last_idx) begin
          state_next = ST_IDLE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      last_idx <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
      last_idx <= last_idx_next;
    end
  end

  always_comb begin
    ctrl.load = accept && gives_steps;
    ctrl.emit = (state == ST_RUN);
    ctrl.last = (step == last_idx);
    ctrl.step = step;
  end

endmodule
`default_nettype wire

// File: rtl/lcdnws_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnws_dp
// configuration registers, byte latch and pin step generation
// ----------------------------------------------------------------------------
module lcdnws_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [lcdnws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lcdnws_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [1:0]                           cmd,
  input  wire logic [7:0]                           byte_value,
  input  wire logic [7:0]                           column,
  input  wire logic [2:0]                           row,
  input  wire lcdnws_pkg::ctrl_cmd_t                ctrl,
  output logic                                      step_valid,
  output logic                                      reg_select,
  output logic                                      enable_pin,
  output logic [3:0]                                data_nibble,
  output logic [lcdnws_pkg::HOLD_W-1:0]             hold_us,
  output logic                                      last_step
);

  logic [6:0] row0_start, row1_start, row2_start, row3_start;
  logic [7:0] function_set_code, entry_mode_code, display_on_code;

  // latched request
  logic       run_init;
  logic       run_rs;
  logic [7:0] run_code;

  logic [6:0] sel_start;
  logic [7:0] load_code;

  logic [lcdnws_pkg::STEP_W-1:0] t;
  logic [2:0] instr_sel;
  logic [1:0] sub;
  logic [7:0] code;
  logic       en;
  logic       from_code;
  logic       settle;
  logic [3:0] const_nib;
  logic [lcdnws_pkg::HOLD_W-1:0] const_hold;
  logic [3:0] nib;
  logic [lcdnws_pkg::HOLD_W-1:0] hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_start <= 7'd0;
      row1_start <= 7'd64;
      row2_start <= 7'd20;
      row3_start <= 7'd84;
      function_set_code <= 8'h28;
      entry_mode_code <= 8'h06;
      display_on_code <= 8'h0C;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdnws_pkg::REG_ROW0:    row0_start <= cfg_data[6:0];
        lcdnws_pkg::REG_ROW1:    row1_start <= cfg_data[6:0];
        lcdnws_pkg::REG_ROW2:    row2_start <= cfg_data[6:0];
        lcdnws_pkg::REG_ROW3:    row3_start <= cfg_data[6:0];
        lcdnws_pkg::REG_FSET:    function_set_code <= cfg_data;
        lcdnws_pkg::REG_ENTRY:   entry_mode_code <= cfg_data;
        lcdnws_pkg::REG_DISP_ON: display_on_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (row[1:0])
      2'd0:    sel_start = row0_start;
      2'd1:    sel_start = row1_start;
      2'd2:    sel_start = row2_start;
      default: sel_start = row3_start;
    endcase
    if (cmd == lcdnws_pkg::CMD_CURSOR) begin
      load_code = lcdnws_pkg::CODE_DDRAM + {1'b0, sel_start} + column;
    end else begin
      load_code = byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      run_init <= (cmd == lcdnws_pkg::CMD_INIT);
      run_rs <= (cmd == lcdnws_pkg::CMD_CHAR);
      run_code <= load_code;
    end
  end

  // init steps from nine on are five instructions of four steps each
  assign t = ctrl.step - lcdnws_pkg::INIT_INSTR_BASE;
  assign instr_sel = t[4:2];

  always_comb begin
    en = 1'b0;
    from_code = 1'b1;
    const_nib = 4'h0;
    const_hold = lcdnws_pkg::HOLD_STROBE;
    sub = ctrl.step[1:0];
    code = run_code;
    if (run_init) begin
      sub = t[1:0];
      case (instr_sel)
        3'd0:    code = function_set_code;
        3'd1:    code = lcdnws_pkg::CODE_DISPLAY_OFF;
        3'd2:    code = lcdnws_pkg::CODE_CLEAR;
        3'd3:    code = entry_mode_code;
        default: code = display_on_code;
      endcase
      if (ctrl.step < lcdnws_pkg::INIT_INSTR_BASE) begin
        from_code = 1'b0;
        en = ctrl.step[0];
        // the fourth wake-up nibble (steps seven and eight) switches to 4-bit mode
        const_nib = (ctrl.step == 5'd7 || ctrl.step == 5'd8) ? 4'h2 : 4'h3;
        case (ctrl.step)
          5'd0:    begin const_hold = lcdnws_pkg::HOLD_POWER_UP; const_nib = 4'h0; end
          5'd2:    const_hold = lcdnws_pkg::HOLD_WAKE1;
          5'd4:    const_hold = lcdnws_pkg::HOLD_WAKE2;
          5'd8:    const_hold = lcdnws_pkg::HOLD_WAKE4;
          default: const_hold = lcdnws_pkg::HOLD_STROBE;
        endcase
      end
    end
    if (from_code) begin
      en = !sub[0];
    end
    settle = from_code && (sub == 2'd3);
    nib = from_code ? (sub[1] ? code[3:0] : code[7:4]) : const_nib;
    if (settle) begin
      hold = (!run_rs && code == lcdnws_pkg::CODE_CLEAR) ? lcdnws_pkg::HOLD_CLEAR
                                                         : lcdnws_pkg::HOLD_INSTR;
    end else begin
      hold = const_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else begin
      step_valid <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      reg_select <= run_rs;
      enable_pin <= en;
      data_nibble <= nib;
      hold_us <= hold;
      last_step <= ctrl.last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/char_lcd_nibble_write_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top
// turns init, instruction, character and cursor requests into timed lcd pin
// steps for a 4-bit character display
// ----------------------------------------------------------------------------
// steps: the request is registered in the controller state, each step in the
//   output registers, one step per cycle: 29 for init, 4 for the others, none
//   for rows above three; a new request is taken only while idle, not while the
//   step counter of the controller walks a run one step a cycle
// reset: synchronous; configuration registers return to their defaults, no run
// the receiver cannot stall: each step is valid for exactly one cycle
module char_lcd_nibble_write_sequencer_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request port
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           cmd,
  input  wire logic [7:0]                           byte_value,
  input  wire logic [7:0]                           column,
  input  wire logic [2:0]                           row,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [lcdnws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lcdnws_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pin step results
  output logic                                      step_valid,
  output logic                                      reg_select,
  output logic                                      enable_pin,
  output logic [3:0]                                data_nibble,
  output logic [lcdnws_pkg::HOLD_W-1:0]             hold_us,
  output logic                                      last_step
);

  // command bundle from the controller: load, emit, step index, last flag
  lcdnws_pkg::ctrl_cmd_t ctrl;

  // controller: accepts a request and walks the step index of its run
  lcdnws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .row   (row),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // datapath: holds registers and the request byte, builds each pin step
  lcdnws_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .byte_value  (byte_value),
    .column      (column),
    .row         (row),
    .ctrl        (ctrl),
    .step_valid  (step_valid),
    .reg_select  (reg_select),
    .enable_pin  (enable_pin),
    .data_nibble (data_nibble),
    .hold_us     (hold_us),
    .last_step   (last_step)
  );

  // after a run's last step, step_valid drops before the next request can produce steps
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    step_valid && last_step |=> !step_valid)
    else $error("step right after last step");

  // a request that yields steps starts a run
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(cmd == lcdnws_pkg::CMD_CURSOR && row[2]) |=> busy)
    else $error("request did not start a run");

  // each busy cycle delivers one step on the next cycle
  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> step_valid)
    else $error("busy cycle without a step");

  // enable high steps are always the short strobe
  a_strobe_hold: assert property (@(posedge clk) disable iff (rst)
    step_valid && enable_pin |-> hold_us == lcdnws_pkg::HOLD_STROBE)
    else $error("enable strobe with wrong hold");

endmodule
`default_nettype wire
